@@ rtl/sdf_pkg.sv @@
// Shared types and state codes for the stream duplicate filter.
`timescale 1ns / 1ps
package sdf_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned CountOutWidth = 7;

  typedef struct packed {
    logic signed [ValueWidth-1:0] item_value;
    logic                         start_new;
  } sdf_in_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0]  kept_value;
    logic                          is_new;
    logic [CountOutWidth-1:0]      unique_count;
    logic                          overflow;
  } sdf_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } sdf_state_t;

endpackage

@@ rtl/sdf_in_if.sv @@
// Input channel interface: valid/ready handshake with one element per beat.
`timescale 1ns / 1ps
interface sdf_in_if
  import sdf_pkg::*;
();
  logic    valid;
  logic    ready;
  sdf_in_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/sdf_out_if.sv @@
// Output channel interface: valid/ready handshake with one result per beat.
`timescale 1ns / 1ps
interface sdf_out_if
  import sdf_pkg::*;
();
  logic     valid;
  logic     ready;
  sdf_out_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/stream_duplicate_filter_unit.sv @@
// Top level of the stream duplicate filter: sequencer, seen table and result register.
//
// Usage:
//   item   : input channel, one signed 32-bit element per beat plus start_new.
//            start_new = 1 empties the seen table before that element.
//   result : output channel, exactly one beat per element: the element echoed,
//            is_new, the running unique count (low 7 bits) and overflow.
// Sequencing:
//   An element is taken only in the idle state. It then scans the stored
//   values through the single read port of the seen table, one entry per
//   cycle, stopping early on a match. At most the stored count, and so at
//   most CAPACITY, entries are compared. The result is then registered in
//   the finish step, and the sequencer returns to idle before the next
//   element is accepted.
// Reset:
//   rst clears the stored count and the control state; the table contents are
//   not cleared, since only entries below the count are ever read.
// Stall:
//   The result register holds a finished beat while the receiver stalls, and
//   the next element is still accepted and scanned meanwhile; the sequencer
//   waits in its finish step only if the previous beat has not been taken.
`timescale 1ns / 1ps
module stream_duplicate_filter_unit
  import sdf_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input logic      clk,
  input logic      rst,
  sdf_in_if.sink   item,
  sdf_out_if.source result
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CapCount = CW'(CAPACITY);

  sdf_state_t state, state_next;

  logic [CW-1:0]         count;      // stored unique values in current array
  logic [CW-1:0]         idx;        // next table entry to read
  logic                  pend;       // read data valid this cycle
  logic                  hit;        // match found during scan
  logic [ValueWidth-1:0] value;      // element under test

  logic                  accept;
  logic                  rd_issue;
  logic                  match;
  logic                  finish_go;
  logic                  store;
  logic [ValueWidth-1:0] rdata;
  logic                  out_valid;
  sdf_out_t              out_data;

  assign accept = item.valid && item.ready;
  assign match  = pend && (rdata == value);

  // Seen table: one read per scan cycle, one write when a new value is stored.
  sdf_ram #(
    .WIDTH (ValueWidth),
    .DEPTH (CAPACITY)
  ) u_table (
    .clk   (clk),
    .we    (store),
    .waddr (count[AW-1:0]),
    .wdata (value),
    .raddr (idx[AW-1:0]),
    .rdata (rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Stop on a match, or when every stored entry has been compared.
        if (match || (!rd_issue && !pend)) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (finish_go) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    item.ready = 1'b0;
    rd_issue   = 1'b0;
    finish_go  = 1'b0;
    store      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        item.ready = 1'b1;
      end
      ST_SCAN: begin
        rd_issue = (idx < count) && !match;
      end
      ST_FINISH: begin
        finish_go = !out_valid || result.ready;
        store     = finish_go && !hit && (count < CapCount);
      end
      default: begin
        item.ready = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      pend      <= 1'b0;
      hit       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        // Start flag empties the table before this element is examined.
        if (item.data.start_new) begin
          count <= '0;
        end
        idx  <= '0;
        pend <= 1'b0;
        hit  <= 1'b0;
      end else if (state == ST_SCAN) begin
        pend <= rd_issue;
        if (rd_issue) begin
          idx <= idx + 1'b1;
        end
        if (match) begin
          hit <= 1'b1;
        end
      end
      if (store) begin
        count <= count + 1'b1;
      end
      if (finish_go) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      value <= item.data.item_value;
    end
    if (finish_go) begin
      out_data.kept_value   <= value;
      out_data.is_new       <= store;
      out_data.unique_count <= CountOutWidth'(store ? count + 1'b1 : count);
      out_data.overflow     <= !hit && (count >= CapCount);
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

endmodule

@@ rtl/sdf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sdf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
